// ===== src/wrps_pkg.sv =====
// Shared constants and types for the weighted random pool select unit.
// Depends on nothing; every other file imports it.
package wrps_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 15;
	localparam int WEIGHT_W = 16;
	localparam int RND_W    = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int TOT_W    = WEIGHT_W + $clog2(CAPACITY);
	localparam int ENTRY_W  = KEY_W + WEIGHT_W;
	localparam int DCNT_W   = $clog2(RND_W);

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_ADD   = 2'd1,
		KIND_PICK  = 2'd2,
		KIND_SPARE = 2'd3
	} wrps_kind_t;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_SCAN  = 10'b00_0000_0010,
		ST_CMP   = 10'b00_0000_0100,
		ST_SHIFT = 10'b00_0000_1000,
		ST_MOVE  = 10'b00_0001_0000,
		ST_DIV   = 10'b00_0010_0000,
		ST_UOUT  = 10'b00_0100_0000,
		ST_WRD   = 10'b00_1000_0000,
		ST_WCMP  = 10'b01_0000_0000,
		ST_DONE  = 10'b10_0000_0000
	} wrps_state_t;

endpackage

// ===== src/wrps_if.sv =====
// Valid/ready channel interfaces for the command and result words.
// Depends on wrps_pkg for the field widths.
interface wrps_cmd_if import wrps_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 kind;
	logic signed [KEY_W:0]      entry_key;
	logic [WEIGHT_W-1:0]        entry_weight;
	logic                       pick_mode;
	logic [RND_W-1:0]           random_word;

	modport source(output valid, kind, entry_key, entry_weight, pick_mode, random_word,
		input ready);
	modport sink(input valid, kind, entry_key, entry_weight, pick_mode, random_word,
		output ready);
endinterface

interface wrps_res_if import wrps_pkg::*;;
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] picked_key;
	logic             accepted;

	modport source(output valid, picked_key, accepted, input ready);
	modport sink(input valid, picked_key, accepted, output ready);
endinterface

// ===== src/wrps_mod.sv =====
// Iterative remainder unit: one restoring step per cycle over the random word.
// Depends on wrps_pkg.
module wrps_mod import wrps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RND_W-1:0] dividend,
	input  logic [TOT_W-1:0] divisor,
	output logic             done,
	output logic [TOT_W-1:0] rem
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [RND_W-1:0]  dvd_q;
	logic [TOT_W-1:0]  dsr_q;
	logic [TOT_W-1:0]  rem_q;
	logic [TOT_W:0]    trial;
	logic [TOT_W:0]    diff;

	// bring down the next dividend bit and subtract where it fits
	assign trial = {rem_q, dvd_q[RND_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == DCNT_W'(RND_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(RND_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= diff[TOT_W-1:0];
			end else begin
				rem_q <= trial[TOT_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== src/weighted_random_pool_select_unit.sv =====
// Top level of the weighted random pool select unit (roulette-wheel selection).
// Depends on wrps_pkg, wrps_if (wrps_cmd_if, wrps_res_if) and wrps_mod.
//
//   channel | role  | word carries
//   --------+-------+----------------------------------------------------
//   cmd     | sink  | kind, entry_key, entry_weight, pick_mode, random_word
//   res     | source| picked_key, accepted
//
// Sequence: clear and the spare kind go straight to the done state; an add
// searches by position for its slot, then moves each larger entry up one
// place; a pick on a non-empty pool runs the remainder unit, then reads one
// entry for a uniform pick or walks the entries for a proportional one.
// The entry memory gives one registered access a cycle, so each search, shift
// or walk step takes a read state and then a compare or move state.
// Reset empties the pool at once; entry memory needs no clearing pass.
// A finished result waits in the output register, so a new word is taken
// while the previous result is still held; processing stalls only at the end.
module weighted_random_pool_select_unit import wrps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	wrps_cmd_if.sink   cmd,
	wrps_res_if.source res
);

	wrps_state_t        state_q;
	logic [CNT_W-1:0]   entry_count_q;
	logic [TOT_W-1:0]   weight_total_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   sh_q;
	logic [TOT_W-1:0]   running_q;
	logic               uniform_q;
	logic [KEY_W-1:0]   key_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [KEY_W-1:0]   key_out_q;
	logic               ok_out_q;
	logic               res_valid_q;
	logic [KEY_W-1:0]   picked_key_q;
	logic               accepted_q;

	// entry memory: key in the upper bits, weight in the lower
	logic [ENTRY_W-1:0] entry_mem [CAPACITY];
	logic [ENTRY_W-1:0] rd_q;
	logic               mem_re;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_ra;
	logic [IDX_W-1:0]   mem_wa;
	logic [ENTRY_W-1:0] mem_wd;

	logic               div_start;
	logic               div_done;
	logic [TOT_W-1:0]   div_rem;
	logic [TOT_W-1:0]   div_divisor;
	logic               pick_uniform;

	logic [KEY_W-1:0]   rd_key;
	logic [WEIGHT_W-1:0] rd_weight;
	logic [TOT_W-1:0]   run_next;
	logic               cmd_take;
	logic               res_load;
	wrps_kind_t         cmd_kind;

	assign rd_key    = rd_q[ENTRY_W-1:WEIGHT_W];
	assign rd_weight = rd_q[WEIGHT_W-1:0];
	assign run_next  = running_q + TOT_W'(rd_weight);
	assign cmd_kind  = wrps_kind_t'(cmd.kind);

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_take  = cmd.valid && cmd.ready;
	// free the output register when it is empty or being drained this cycle
	assign res_load  = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	// uniform by position when asked, or when every weight is zero
	assign pick_uniform = !cmd.pick_mode || (weight_total_q == '0);
	assign div_divisor  = pick_uniform ? TOT_W'(entry_count_q) : weight_total_q;
	assign div_start    = cmd_take && (cmd_kind == KIND_PICK) && (entry_count_q != '0);

	wrps_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cmd.random_word),
		.divisor  (div_divisor),
		.done     (div_done),
		.rem      (div_rem)
	);

	// memory port selection by state
	always_comb begin
		mem_re = 1'b0;
		mem_ra = '0;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		case (state_q)
			ST_SCAN: begin
				mem_re = (idx_q != entry_count_q);
				mem_ra = idx_q[IDX_W-1:0];
			end
			ST_SHIFT: begin
				if (sh_q == idx_q) begin
					mem_we = 1'b1;
					mem_wa = idx_q[IDX_W-1:0];
					mem_wd = {key_q, weight_q};
				end else begin
					mem_re = 1'b1;
					mem_ra = IDX_W'(sh_q - 1'b1);
				end
			end
			ST_MOVE: begin
				mem_we = 1'b1;
				mem_wa = sh_q[IDX_W-1:0];
				mem_wd = rd_q;
			end
			ST_DIV: begin
				mem_re = div_done && uniform_q;
				mem_ra = div_rem[IDX_W-1:0];
			end
			ST_WRD: begin
				mem_re = 1'b1;
				mem_ra = idx_q[IDX_W-1:0];
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= entry_mem[mem_ra];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			entry_count_q  <= '0;
			weight_total_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						case (cmd_kind)
							KIND_CLEAR: begin
								entry_count_q  <= '0;
								weight_total_q <= '0;
								state_q        <= ST_DONE;
							end
							KIND_ADD: begin
								// reject a negative key or a full pool at once
								if (cmd.entry_key[KEY_W] ||
								    entry_count_q == CNT_W'(CAPACITY)) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							KIND_PICK: begin
								if (entry_count_q == '0) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_DIV;
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (idx_q == entry_count_q) begin
						state_q <= ST_SHIFT;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (rd_key < key_q) begin
						state_q <= ST_SCAN;
					end else if (rd_key == key_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (sh_q == idx_q) begin
						entry_count_q  <= entry_count_q + 1'b1;
						weight_total_q <= weight_total_q + TOT_W'(weight_q);
						state_q        <= ST_DONE;
					end else begin
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					state_q <= ST_SHIFT;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= uniform_q ? ST_UOUT : ST_WRD;
					end
				end
				ST_UOUT: begin
					state_q <= ST_DONE;
				end
				ST_WRD: begin
					state_q <= ST_WCMP;
				end
				ST_WCMP: begin
					if (run_next > div_rem) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_WRD;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers and the result under construction
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q     <= cmd.entry_key[KEY_W-1:0];
				weight_q  <= cmd.entry_weight;
				uniform_q <= pick_uniform;
				idx_q     <= '0;
				running_q <= '0;
				key_out_q <= '0;
				ok_out_q  <= (cmd_kind == KIND_CLEAR);
			end
			ST_SCAN: begin
				sh_q <= entry_count_q;
			end
			ST_CMP: begin
				// advance past smaller keys; a duplicate leaves the pool alone
				if (rd_key < key_q) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_SHIFT: begin
				ok_out_q <= (sh_q == idx_q);
			end
			ST_MOVE: begin
				sh_q <= sh_q - 1'b1;
			end
			ST_UOUT: begin
				key_out_q <= rd_key;
				ok_out_q  <= 1'b1;
			end
			ST_WCMP: begin
				if (run_next > div_rem) begin
					key_out_q <= rd_key;
					ok_out_q  <= 1'b1;
				end else begin
					running_q <= run_next;
					idx_q     <= idx_q + 1'b1;
				end
			end
			default: begin
				running_q <= running_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			picked_key_q <= key_out_q;
			accepted_q   <= ok_out_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.picked_key = picked_key_q;
	assign res.accepted   = accepted_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		(entry_count_q == '0) |-> (weight_total_q == '0))
		else $error("empty pool with non-zero weight total");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("remainder finished outside pick");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.accepted) |-> (res.picked_key == '0))
		else $error("rejected word carries a key");

	a_ready_load: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> res_valid_q)
		else $error("result lost at output register");

endmodule
